// File: rtl/lcr_pkg.sv
`timescale 1ns / 1ps
package lcr_pkg;

	localparam int WIDE_W = 128;
	localparam int MULB_W = 48;
	localparam int VAL_W = 48;
	localparam int CAL_SAMPLES_DEF = 10;

	// 2*pi in Q32, rounded
	localparam logic [34:0] TWO_PI_Q32 = 35'd26986075409;
	localparam logic [39:0] PICO = 40'd1000000000000;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_DATA  = 3'd1,
		ST_ZERO_MAG = 3'd2,
		ST_NO_CAL   = 3'd3,
		ST_SAT      = 3'd4
	} status_t;

	localparam logic [1:0] KIND_IND = 2'd0;
	localparam logic [1:0] KIND_CAP = 2'd1;
	localparam logic MODE_CAL = 1'b0;
	localparam logic REG_CAL_RES = 1'b0;
	localparam logic REG_TEST_FREQ = 1'b1;

	typedef struct packed {
		logic              done;
		logic [WIDE_W-1:0] prod;
	} mul_res_t;

	typedef struct packed {
		logic             done;
		logic             sat;
		logic [VAL_W-1:0] quo;
	} div_res_t;

	typedef struct packed {
		logic        done;
		logic [15:0] root;
	} sqrt_res_t;

endpackage

// File: rtl/lcr_sqrt.sv
`timescale 1ns / 1ps
module lcr_sqrt
	import lcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] radicand,
	output sqrt_res_t   res
);

	logic [31:0] v_q, res_q, bit_q;
	logic        busy_q, done_q;
	logic [31:0] trial;

	assign trial = res_q + bit_q;
	assign res.done = done_q;
	assign res.root = res_q[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == 32'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= 32'h4000_0000;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

// File: rtl/lcr_mul.sv
`timescale 1ns / 1ps
module lcr_mul
	import lcr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WIDE_W-1:0] a,
	input  logic [MULB_W-1:0] b,
	output mul_res_t          res
);

	localparam int CNT_W = $clog2(MULB_W + 1);

	logic [WIDE_W-1:0] a_q, p_q;
	logic [MULB_W-1:0] b_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q;

	assign res.done = done_q;
	assign res.prod = p_q;

	// shift-add, one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MULB_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (busy_q) begin
			if (b_q[0])
				p_q <= p_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

endmodule

// File: rtl/lcr_div.sv
`timescale 1ns / 1ps
module lcr_div
	import lcr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WIDE_W-1:0] num,
	input  logic [WIDE_W-1:0] den,
	output div_res_t          res
);

	localparam int CNT_W = $clog2(WIDE_W + 1);

	logic [WIDE_W-1:0] num_q, den_q, rem_q;
	logic [VAL_W-1:0]  q_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q;
	logic [WIDE_W:0]   rem_sh, diff;
	logic              qbit;

	assign rem_sh = {rem_q, num_q[WIDE_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign qbit   = !diff[WIDE_W];

	assign res.done = done_q;
	assign res.sat  = ovf_q;
	assign res.quo  = ovf_q ? {VAL_W{1'b1}} : q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDE_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division; any quotient bit above the kept width flags saturation
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= qbit ? diff[WIDE_W-1:0] : rem_sh[WIDE_W-1:0];
			q_q   <= {q_q[VAL_W-2:0], qbit};
			ovf_q <= ovf_q | q_q[VAL_W-1];
		end
	end

endmodule

// File: rtl/impedance_lcr_calculator.sv
`timescale 1ns / 1ps
// channel   dir  tdata                      tuser
// s_axis    in   real_part, imag_part       mode, data_valid, network_kind
// m_axis    out  value                      status, calibrated
// cfg       in   cfg_data (index 0 cal_resistance, 1 test_frequency)
// Steps from accept to result: an invalid, zero or uncalibrated reading takes
// two squares and the root; calibration one multiply and one divide, plus a
// second divide when the mean is formed; resistor one multiply and one divide;
// L or C three multiplies and one divide.
// One beat in flight; s_axis_tready is low until the result sits in the output
// register. Reset clears all calibration state; registers return to defaults.
module impedance_lcr_calculator
	import lcr_pkg::*;
#(
	parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // real_part, imag_part
	input  logic [3:0]  s_axis_tuser,   // mode, data_valid, network_kind[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // value
	output logic [3:0]  m_axis_tuser,   // status[2:0], calibrated
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_SQR, S_SQI, S_SQRT, S_CHK, S_M1, S_M2, S_M3, S_DIV, S_MEAN, S_OUT
	} state_t;

	state_t            state_q;
	logic [23:0]       cal_res_q;
	logic [16:0]       freq_q;
	logic [55:0]       gain_sum_q;
	logic [3:0]        cal_count_q;
	logic [47:0]       gain_q;
	logic              gain_ready_q;
	logic              launched_q;

	logic              mode_q, valid_q;
	logic [1:0]        kind_q;
	logic signed [15:0] re_q, im_q;
	logic [31:0]       sq_q;
	logic [15:0]       mag_q;
	logic [WIDE_W-1:0] num_q, den_q;
	logic [47:0]       res_value_q;
	status_t           res_status_q;

	logic              out_valid_q, out_cal_q;
	logic [47:0]       out_value_q;
	status_t           out_status_q;

	logic              sqrt_start, mul_start, div_start;
	logic [WIDE_W-1:0] mul_a;
	logic [MULB_W-1:0] mul_b;
	sqrt_res_t         sqrt_res;
	mul_res_t          mul_res;
	div_res_t          div_res;
	logic signed [15:0] sq_op;
	logic signed [31:0] sq_prod;
	logic [23:0]       r_eff;
	logic [16:0]       f_eff;
	logic [55:0]       sum_next;
	logic [4:0]        count_next;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_value_q;
	assign m_axis_tuser  = {out_cal_q, out_status_q};

	assign r_eff = (cal_res_q == '0) ? 24'd1 : cal_res_q;
	assign f_eff = (freq_q == '0) ? 17'd1 : freq_q;
	assign sq_op = (state_q == S_SQR) ? re_q : im_q;
	assign sq_prod = sq_op * sq_op;
	assign sum_next = gain_sum_q + {8'd0, div_res.quo};
	assign count_next = {1'b0, cal_count_q} + 5'd1;

	assign sqrt_start = (state_q == S_SQRT) && !launched_q;
	assign mul_start  = (state_q == S_M1 || state_q == S_M2 || state_q == S_M3) && !launched_q;
	assign div_start  = (state_q == S_DIV || state_q == S_MEAN) && !launched_q;

	always_comb begin
		mul_a = den_q;
		mul_b = MULB_W'(f_eff);
		unique case (state_q)
			S_M1: begin
				mul_a = (mode_q == MODE_CAL) ? WIDE_W'(r_eff) : WIDE_W'(gain_q);
				mul_b = MULB_W'(mag_q);
			end
			S_M2: begin
				mul_b = (kind_q == KIND_CAP) ? MULB_W'(PICO) : MULB_W'(TWO_PI_Q32);
			end
			S_M3: begin
				if (kind_q == KIND_CAP)
					mul_a = WIDE_W'(TWO_PI_Q32);
			end
			default: ;
		endcase
	end

	lcr_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sq_q),
		.res      (sqrt_res)
	);

	lcr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.res    (mul_res)
	);

	lcr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_res_q <= 24'd10000;
			freq_q    <= 17'd30000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAL_RES:   cal_res_q <= cfg_data;
				REG_TEST_FREQ: freq_q    <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			launched_q   <= 1'b0;
			gain_sum_q   <= '0;
			cal_count_q  <= '0;
			gain_q       <= '0;
			gain_ready_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_cal_q    <= 1'b0;
			out_status_q <= ST_OK;
			res_status_q <= ST_OK;
			mode_q       <= 1'b0;
			valid_q      <= 1'b0;
			kind_q       <= '0;
			re_q         <= '0;
			im_q         <= '0;
			sq_q         <= '0;
			mag_q        <= '0;
			num_q        <= '0;
			den_q        <= '0;
			res_value_q  <= '0;
			out_value_q  <= '0;
		end else begin
			if (out_valid_q && m_axis_tready && state_q != S_OUT)
				out_valid_q <= 1'b0;
			if (sqrt_start || mul_start || div_start)
				launched_q <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						re_q    <= s_axis_tdata[15:0];
						im_q    <= s_axis_tdata[31:16];
						mode_q  <= s_axis_tuser[0];
						valid_q <= s_axis_tuser[1];
						kind_q  <= s_axis_tuser[3:2];
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					sq_q    <= 32'(unsigned'(sq_prod));
					state_q <= S_SQI;
				end
				S_SQI: begin
					sq_q    <= sq_q + 32'(unsigned'(sq_prod));
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (sqrt_res.done) begin
						launched_q <= 1'b0;
						mag_q      <= sqrt_res.root;
						state_q    <= S_CHK;
					end
				end
				S_CHK: begin
					res_value_q <= '0;
					if (!valid_q) begin
						res_status_q <= ST_NO_DATA;
						state_q      <= S_OUT;
					end else if (mag_q == '0) begin
						res_status_q <= ST_ZERO_MAG;
						state_q      <= S_OUT;
					end else if (mode_q != MODE_CAL && (!gain_ready_q || gain_q == '0)) begin
						res_status_q <= ST_NO_CAL;
						state_q      <= S_OUT;
					end else begin
						state_q <= S_M1;
					end
				end
				S_M1: begin
					if (mul_res.done) begin
						launched_q <= 1'b0;
						den_q      <= mul_res.prod;
						if (mode_q == MODE_CAL) begin
							num_q   <= WIDE_W'(1) << 48;
							state_q <= S_DIV;
						end else if (kind_q == KIND_IND || kind_q == KIND_CAP) begin
							state_q <= S_M2;
						end else begin
							num_q   <= WIDE_W'(1) << 56;
							state_q <= S_DIV;
						end
					end
				end
				S_M2: begin
					if (mul_res.done) begin
						launched_q <= 1'b0;
						if (kind_q == KIND_CAP)
							num_q <= mul_res.prod;
						else
							den_q <= mul_res.prod;
						state_q <= S_M3;
					end
				end
				S_M3: begin
					if (mul_res.done) begin
						launched_q <= 1'b0;
						if (kind_q == KIND_CAP) begin
							den_q <= mul_res.prod << 16;
						end else begin
							den_q <= mul_res.prod;
							num_q <= {8'd0, PICO, 80'd0};
						end
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_res.done) begin
						launched_q   <= 1'b0;
						res_status_q <= div_res.sat ? ST_SAT : ST_OK;
						if (mode_q == MODE_CAL) begin
							if (count_next >= 5'(CAL_SAMPLES)) begin
								num_q       <= WIDE_W'(sum_next);
								den_q       <= WIDE_W'(CAL_SAMPLES);
								gain_sum_q  <= '0;
								cal_count_q <= '0;
								state_q     <= S_MEAN;
							end else begin
								gain_sum_q  <= sum_next;
								cal_count_q <= count_next[3:0];
								state_q     <= S_OUT;
							end
						end else begin
							res_value_q <= div_res.quo;
							state_q     <= S_OUT;
						end
					end
				end
				S_MEAN: begin
					if (div_res.done) begin
						launched_q   <= 1'b0;
						gain_q       <= div_res.quo;
						gain_ready_q <= 1'b1;
						state_q      <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q  <= 1'b1;
						out_value_q  <= res_value_q;
						out_status_q <= res_status_q;
						out_cal_q    <= gain_ready_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: tb/impedance_lcr_calculator_tb.sv
`timescale 1ns / 1ps
module impedance_lcr_calculator_tb;
	import lcr_pkg::*;

	localparam int CAL_N = CAL_SAMPLES_DEF;
	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;

	class lcr_scoreboard;
		typedef struct {
			logic [47:0] value;
			status_t     status;
			bit          calibrated;
		} reading_t;

		reading_t    pending[$];
		int          errors = 0;
		logic [23:0] cal_res = 24'd10000;
		logic [16:0] freq = 17'd30000;
		logic [55:0] gain_acc = '0;
		logic [3:0]  gain_cnt = '0;
		logic [47:0] gain = '0;
		bit          gain_valid = 0;

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function automatic logic [15:0] isqrt(logic [31:0] v);
			logic [32:0] acc, root, bitv;
			acc = v;
			root = '0;
			bitv = 33'd1 << 30;
			while (bitv > acc) bitv >>= 2;
			while (bitv != 0) begin
				if (acc >= root + bitv) begin
					acc -= root + bitv;
					root = (root >> 1) + bitv;
				end else begin
					root >>= 1;
				end
				bitv >>= 2;
			end
			return root[15:0];
		endfunction

		function void note_reading(bit mode, bit valid, logic signed [15:0] re,
				logic signed [15:0] im, logic [1:0] kind);
			reading_t    exp_r;
			logic [31:0] pwr;
			logic signed [31:0] re_w, im_w;
			logic [15:0] mag;
			logic [63:0] rr, ratio;
			logic [16:0] f;
			logic [255:0] num, den, quo;
			bit          sat;
			exp_r.value = '0;
			exp_r.status = ST_OK;
			sat = 0;
			if (!valid) begin
				exp_r.status = ST_NO_DATA;
			end else begin
				re_w = re;
				im_w = im;
				pwr = 32'(re_w * re_w) + 32'(im_w * im_w);
				mag = isqrt(pwr);
				if (mag == 0) begin
					exp_r.status = ST_ZERO_MAG;
				end else if (mode == MODE_CAL) begin
					rr = (cal_res == 0) ? 64'd1 : 64'(cal_res);
					ratio = (64'd1 << 48) / (rr * mag);
					if (ratio > 64'(MAX48)) begin
						ratio = 64'(MAX48);
						sat = 1;
					end
					gain_acc += ratio[55:0];
					gain_cnt++;
					if (gain_cnt >= CAL_N) begin
						gain = 48'(gain_acc / CAL_N);
						gain_valid = 1;
						gain_acc = '0;
						gain_cnt = '0;
					end
					if (sat) exp_r.status = ST_SAT;
				end else if (!gain_valid || gain == 0) begin
					exp_r.status = ST_NO_CAL;
				end else begin
					f = (freq == 0) ? 17'd1 : freq;
					if (kind == KIND_IND) begin
						num = 256'(PICO) << 80;
						den = 256'(TWO_PI_Q32) * f * gain * mag;
					end else if (kind == KIND_CAP) begin
						num = 256'(PICO) * gain * mag;
						den = (256'(TWO_PI_Q32) * f) << 16;
					end else begin
						num = 256'd1 << 56;
						den = 256'(gain) * mag;
					end
					quo = num / den;
					if (quo > 256'(MAX48)) begin
						exp_r.value = MAX48;
						exp_r.status = ST_SAT;
					end else begin
						exp_r.value = quo[47:0];
					end
				end
			end
			exp_r.calibrated = gain_valid;
			pending.push_back(exp_r);
		endfunction

		task check_result(logic [47:0] value, logic [3:0] user);
			reading_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected beat value=%0d user=%h", value, user));
			end else begin
				e = pending.pop_front();
				if (value !== e.value)
					report($sformatf("value %0d, want %0d", value, e.value));
				if (user[2:0] !== e.status)
					report($sformatf("status %0d, want %0d", user[2:0], e.status));
				if (user[3] !== e.calibrated)
					report($sformatf("calibrated %b, want %b", user[3], e.calibrated));
			end
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [3:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [47:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        cfg_we = 0;
	logic        cfg_index = 0;
	logic [23:0] cfg_data = '0;

	lcr_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	int sent = 0;

	impedance_lcr_calculator dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// enters and leaves at a falling edge
	task send_reading(bit mode, bit valid, logic [15:0] re, logic [15:0] im,
			logic [1:0] kind);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		s_axis_tvalid = 1;
		s_axis_tdata = {im, re};
		s_axis_tuser = {kind, valid, mode};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_reading(mode, valid, re, im, kind);
		sent++;
		@(negedge clk);
		s_axis_tvalid = 0;
	endtask

	task drain;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task write_reg(logic idx, logic [23:0] data);
		drain();
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 0;
		if (idx == REG_CAL_RES) sb.cal_res = data;
		else sb.freq = data[16:0];
	endtask

	function automatic logic [15:0] rand_part();
		logic signed [15:0] v;
		v = 16'($urandom);
		return 16'(v >>> $urandom_range(15));
	endfunction

	task random_burst();
		int n;
		if ($urandom_range(9) < 7) begin
			// full calibration then a run of measurements
			for (int i = 0; i < CAL_N; i++)
				send_reading(MODE_CAL, 1, rand_part(), rand_part(), 2'($urandom));
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				send_reading(!MODE_CAL, ($urandom_range(19) != 0), rand_part(),
					rand_part(), 2'($urandom));
		end else begin
			n = $urandom_range(1, 5);
			for (int i = 0; i < n; i++)
				send_reading(1'($urandom), 1'($urandom), 16'($urandom),
					($urandom_range(3) == 0) ? 16'd0 : rand_part(), 2'($urandom));
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed
		send_reading(!MODE_CAL, 0, 16'h8000, 16'h7FFF, 2'd3);
		send_reading(MODE_CAL, 1, 16'd0, 16'd0, 2'd0);
		send_reading(!MODE_CAL, 1, 16'h7FFF, 16'h8000, KIND_IND);
		// zero resistor reads as one ohm; unit magnitude saturates the ratio
		write_reg(REG_CAL_RES, 24'd0);
		for (int i = 0; i < CAL_N; i++)
			send_reading(MODE_CAL, 1, (i % 2) ? 16'hFFFF : 16'd1, 16'd0, 2'd0);
		write_reg(REG_TEST_FREQ, 24'd0);
		for (int k = 0; k < 4; k++)
			send_reading(!MODE_CAL, 1, 16'h8000, 16'h8000, 2'(k));
		write_reg(REG_CAL_RES, 24'hFFFFFF);
		write_reg(REG_TEST_FREQ, 24'd100000);
		for (int k = 0; k < 4; k++)
			send_reading(!MODE_CAL, 1, 16'd0, 16'd1, 2'(k));
		send_reading(!MODE_CAL, 0, 16'd0, 16'd0, 2'd0);

		sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 59; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 59; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			case (ph)
				0: write_reg(REG_CAL_RES, 24'd1);
				1: write_reg(REG_CAL_RES, 24'd10000);
				2: write_reg(REG_CAL_RES, 24'hFFFFFF);
				default: write_reg(REG_CAL_RES, 24'($urandom_range(1, 24'hFFFFFF)));
			endcase
			case (ph)
				0: write_reg(REG_TEST_FREQ, 24'd100000);
				1: write_reg(REG_TEST_FREQ, 24'd1);
				default: write_reg(REG_TEST_FREQ, 24'($urandom_range(1, 100000)));
			endcase
			while (sent < (ph + 1) * 175) begin
				random_burst();
				if (sent % 40 < 8) drain();
			end
		end
		// hold off the sender until the block has emptied out
		drain();
		send_reading(!MODE_CAL, 1, rand_part(), rand_part(), KIND_CAP);

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
